// ----- design/vnl_pkg.sv -----
// Package for the L2 vector normaliser: constants, beat types and state codes.
`default_nettype none
package vnl_pkg;

   // Store depth default
   localparam int MAX_LEN_DEF = 16;
   // Element width and Q2.14 scaling
   localparam int ELEM_W      = 16;
   localparam int UNIT_SHIFT  = 14;
   // Quotient magnitude never exceeds 16384, so 15 bits
   localparam int QUO_W       = 15;
   // |element| << 14 fits in 30 bits
   localparam int DIVD_W      = ELEM_W + UNIT_SHIFT;
   // Width of one square (2^30 worst case)
   localparam int SQ_W        = 2 * ELEM_W - 1;
   // Defaults for the sub-units at the default store depth
   localparam int SUM_W_DEF   = SQ_W + $clog2(MAX_LEN_DEF + 1);
   localparam int ROOT_W_DEF  = (SUM_W_DEF + 1) / 2;

   // Input beat
   typedef struct packed {
      logic signed [ELEM_W-1:0] element;
      logic                     final_req;
   } req_type;

   // Result beat
   typedef struct packed {
      logic signed [ELEM_W-1:0] unit_element;
      logic                     run_end;
      logic                     dropped;
   } rsp_type;

   // Status of an iterative unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ROOT,
      ST_FETCH,
      ST_PREP,
      ST_DIVIDE,
      ST_SEND
   } state_type;

endpackage
`default_nettype wire

// ----- design/vector_l2_normaliser_unit.sv -----
// Top level of the L2 vector normaliser: element store, sequencer and result register.
`default_nettype none
// Elements arrive one beat per cycle and are written to a single-port store of MAX_LEN
// entries while their squares are summed; beats past MAX_LEN are discarded and mark every
// result of the run as dropped. The beat marked final_req ends the vector: input stalls,
// an iterative square root takes (SUM_W+1)/2 steps, then each stored element is read back
// and divided by the root in a bit-serial divider; each result beat goes through a store
// read, the divider load, 15 divide steps, the divider finish and the send, plus any
// output stall, and the next element waits for that beat to be taken. Results come in arrival
// order, Q2.14, truncated toward zero; a zero root gives zeros. The store is written only
// while loading and read only afterwards, so reads and writes never overlap; no clearing
// pass is needed after reset.
module vector_l2_normaliser_unit #(
   parameter int MAX_LEN = vnl_pkg::MAX_LEN_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  vnl_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output vnl_pkg::rsp_type  rsp_data
);

   localparam int EW     = vnl_pkg::ELEM_W;
   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int SQ_W   = vnl_pkg::SQ_W;
   localparam int SUM_W  = SQ_W + CNT_W;
   localparam int ROOT_W = (SUM_W + 1) / 2;
   localparam int QW     = vnl_pkg::QUO_W;

   vnl_pkg::state_type     state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       rd_cnt_ff, rd_cnt_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   ovf_ff, ovf_in;
   logic [EW-1:0]          rd_data_ff;
   vnl_pkg::rsp_type       rsp_ff;

   logic [EW-1:0]          store_mem [MAX_LEN];

   logic                   req_acc;
   logic                   rsp_acc;
   logic                   store_room;
   logic                   wr_en;
   logic                   rd_en;
   logic                   sqrt_start;
   logic                   div_start;
   logic                   last_item;
   logic signed [2*EW-1:0] square;
   logic [EW-1:0]          magnitude;
   logic [EW-1:0]          q_ext;
   logic [EW-1:0]          unit_val;

   vnl_pkg::unit_stat_type sqrt_stat;
   vnl_pkg::unit_stat_type div_stat;
   logic [ROOT_W-1:0]      root;
   logic [QW-1:0]          quotient;

   assign req_acc    = req_valid && !req_stall;
   assign rsp_acc    = rsp_valid && !rsp_stall;
   assign store_room = (count_ff < CNT_W'(MAX_LEN));
   assign last_item  = ((rd_cnt_ff + CNT_W'(1)) == count_ff);

   // Square of the incoming element
   assign square = req_data.element * req_data.element;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vnl_pkg::ST_LOAD: begin
            if (req_acc && req_data.final_req) state_in = vnl_pkg::ST_ROOT;
         end
         vnl_pkg::ST_ROOT: begin
            if (sqrt_stat.done) state_in = vnl_pkg::ST_FETCH;
         end
         vnl_pkg::ST_FETCH:  state_in = vnl_pkg::ST_PREP;
         vnl_pkg::ST_PREP:   state_in = vnl_pkg::ST_DIVIDE;
         vnl_pkg::ST_DIVIDE: begin
            if (div_stat.done) state_in = vnl_pkg::ST_SEND;
         end
         vnl_pkg::ST_SEND: begin
            if (rsp_acc) state_in = last_item ? vnl_pkg::ST_LOAD : vnl_pkg::ST_FETCH;
         end
         default: state_in = vnl_pkg::ST_LOAD;
      endcase
   end

   // Sequencer outputs; input is never stalled while loading
   always_comb begin
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         vnl_pkg::ST_LOAD: begin
            req_stall  = 1'b0;
            wr_en      = req_valid && store_room;
            sqrt_start = req_valid && req_data.final_req;
         end
         vnl_pkg::ST_FETCH:  rd_en     = 1'b1;
         vnl_pkg::ST_PREP:   div_start = 1'b1;
         vnl_pkg::ST_SEND:   rsp_valid = 1'b1;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Run bookkeeping: count, sum of squares, overflow, read pointer
   always_comb begin
      count_in  = count_ff;
      sum_in    = sum_ff;
      ovf_in    = ovf_ff;
      rd_cnt_in = rd_cnt_ff;
      if (req_acc) begin
         if (store_room) begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_ff + SUM_W'(square[SQ_W-1:0]);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (rsp_acc) begin
         if (last_item) begin
            count_in  = '0;
            sum_in    = '0;
            ovf_in    = 1'b0;
            rd_cnt_in = '0;
         end else begin
            rd_cnt_in = rd_cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= vnl_pkg::ST_LOAD;
         count_ff  <= '0;
         sum_ff    <= '0;
         ovf_ff    <= 1'b0;
         rd_cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         ovf_ff    <= ovf_in;
         rd_cnt_ff <= rd_cnt_in;
      end
   end

   // Element store, one write or one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) store_mem[count_ff[IDX_W-1:0]] <= req_data.element;
      if (rd_en) rd_data_ff <= store_mem[rd_cnt_ff[IDX_W-1:0]];
   end

   // Magnitude of the stored element
   assign magnitude = rd_data_ff[EW-1] ? (~rd_data_ff + EW'(1)) : rd_data_ff;

   vnl_sqrt #(
      .SUM_W (SUM_W)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sum_in),
      .stat    (sqrt_stat),
      .root    (root)
   );

   vnl_div #(
      .DIV_W (ROOT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .magnitude (magnitude),
      .divisor   (root),
      .stat      (div_stat),
      .quotient  (quotient)
   );

   // Sign restore; zero root forces zero
   always_comb begin
      q_ext = {1'b0, quotient};
      if (root == '0) begin
         unit_val = '0;
      end else if (rd_data_ff[EW-1]) begin
         unit_val = ~q_ext + EW'(1);
      end else begin
         unit_val = q_ext;
      end
   end

   // Result register, held while stalled
   always_ff @(posedge clock) begin
      if (div_stat.done) begin
         rsp_ff.unit_element <= unit_val;
         rsp_ff.run_end      <= last_item;
         rsp_ff.dropped      <= ovf_ff;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef NO_ASSERTIONS
   // Stored count never passes the store depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_LEN))
      else $error("element count beyond store depth");

   // Overflow can only be flagged once the store is full
   assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == CNT_W'(MAX_LEN)))
      else $error("overflow flagged with room in the store");

   // The final beat of a run leaves the block empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_data.run_end) |=> (count_ff == '0 && sum_ff == '0 && !ovf_ff))
      else $error("run state not cleared after final result");

   // Normalised magnitude bounded by one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.unit_element <= 16'sd16384 &&
                     rsp_data.unit_element >= -16'sd16384))
      else $error("normalised element out of range");

   // Divider never starts while the root is still being formed
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !sqrt_stat.busy)
      else $error("divider started during square root");
`endif

endmodule
`default_nettype wire

// ----- design/vnl_sqrt.sv -----
// Iterative floor square root, one root bit per cycle.
`default_nettype none
module vnl_sqrt #(
   parameter int SUM_W = vnl_pkg::SUM_W_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire  [SUM_W-1:0]             operand,
   output vnl_pkg::unit_stat_type       stat,
   output logic [(SUM_W+1)/2-1:0]       root
);

   localparam int ROOT_W = (SUM_W + 1) / 2;
   localparam int X_W    = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic [X_W-1:0]    x_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [REM_W+1:0]  rem_sh;
   logic [REM_W+1:0]  trial;
   logic              take;

   // Bring down the next bit pair and try root*4+1
   always_comb begin
      rem_sh = {rem_ff, x_ff[X_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      take   = (rem_sh >= trial);
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROOT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= X_W'(operand);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         x_ff <= {x_ff[X_W-3:0], 2'b00};
         if (take) begin
            rem_ff  <= REM_W'(rem_sh - trial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= REM_W'(rem_sh);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = root_ff;

endmodule
`default_nettype wire

// ----- design/vnl_div.sv -----
// Restoring divider for |element| * 16384 / root, one quotient bit per cycle.
`default_nettype none
module vnl_div #(
   parameter int DIV_W = vnl_pkg::ROOT_W_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire  [vnl_pkg::ELEM_W-1:0]       magnitude,
   input  wire  [DIV_W-1:0]                 divisor,
   output vnl_pkg::unit_stat_type           stat,
   output logic [vnl_pkg::QUO_W-1:0]        quotient
);

   localparam int QW    = vnl_pkg::QUO_W;
   localparam int DW    = vnl_pkg::DIVD_W;
   localparam int REM_W = DIV_W + 1;
   localparam int CNT_W = $clog2(QW + 1);

   logic [DW-1:0]    dividend;
   logic [REM_W-1:0] rem_ff;
   logic [QW-1:0]    q_ff;
   logic [DIV_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [REM_W-1:0] trial;
   logic             take;

   // Remainder stays below the divisor, so its top bit is free for the shift
   always_comb begin
      dividend = {magnitude, {vnl_pkg::UNIT_SHIFT{1'b0}}};
      trial    = {rem_ff[REM_W-2:0], q_ff[QW-1]};
      take     = (trial >= {1'b0, dvs_ff});
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: quotient bits shift in where dividend bits shift out
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= REM_W'(dividend[DW-1:QW]);
         q_ff   <= dividend[QW-1:0];
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (take) begin
            rem_ff <= trial - {1'b0, dvs_ff};
            q_ff   <= {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            q_ff   <= {q_ff[QW-2:0], 1'b0};
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff;

endmodule
`default_nettype wire

// ----- verif/vnl_result_checker.sv -----
// Result checker for the L2 vector normaliser: predicts every result beat and compares it.
module vnl_result_checker
   import vnl_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   input  wire     req_stall,
   input  req_type req_data,
   input  wire     rsp_valid,
   input  wire     rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = MAX_LEN_DEF;
   // Root of at most 16 * 2^30 is 2^17
   localparam int ROOT_BITS   = 18;

   // Predictor state, mirrors the block's store and accumulators
   logic signed [ELEM_W-1:0] held_elems [STORE_DEPTH];
   int                       held_count;
   logic [63:0]              sq_total;
   logic                     spilled;
   rsp_type                  expected_beats [$];

   // Floor square root by setting root bits from the top down
   function automatic logic [ROOT_BITS-1:0] floor_root(input logic [63:0] total);
      logic [ROOT_BITS-1:0] root;
      logic [ROOT_BITS-1:0] trial;
      root = '0;
      for (int b = ROOT_BITS - 1; b >= 0; b--) begin
         trial = root | (ROOT_BITS'(1) << b);
         if (64'(trial) * 64'(trial) <= total) root = trial;
      end
      return root;
   endfunction

   // Store one accepted element; on the last one queue the whole normalised run
   task automatic take_element(input req_type beat);
      logic [ROOT_BITS-1:0] root;
      longint               quo;
      rsp_type              res;
      if (held_count < STORE_DEPTH) begin
         held_elems[held_count] = beat.element;
         held_count++;
         sq_total += 64'(longint'(beat.element) * longint'(beat.element));
      end else begin
         // store full: element discarded, run marked
         spilled = 1'b1;
      end
      if (beat.final_req) begin
         root = floor_root(sq_total);
         for (int k = 0; k < held_count; k++) begin
            if (root == '0) quo = 0;
            else quo = (longint'(held_elems[k]) * (longint'(1) << UNIT_SHIFT)) / longint'(root);
            res.unit_element = ELEM_W'(quo);
            res.run_end      = (k == held_count - 1);
            res.dropped      = spilled;
            expected_beats.push_back(res);
         end
         held_count = 0;
         sq_total   = '0;
         spilled    = 1'b0;
      end
   endtask

   function automatic int field_differs(input string name, input int want, input int got);
      if (want == got) return 0;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
   endfunction

   // Watch both channels at each edge
   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         held_count = 0;
         sq_total   = '0;
         spilled    = 1'b0;
         expected_beats.delete();
         mismatch_count <= 0;
      end else begin
         if (req_valid && !req_stall) take_element(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual %0d/%b/%b",
                        $time, rsp_data.unit_element, rsp_data.run_end, rsp_data.dropped);
               errs = 1;
            end else begin
               want = expected_beats.pop_front();
               errs += field_differs("unit_element", want.unit_element,
                                     rsp_data.unit_element);
               errs += field_differs("run_end", want.run_end, rsp_data.run_end);
               errs += field_differs("dropped", want.dropped, rsp_data.dropped);
            end
         end
         mismatch_count <= mismatch_count + errs;
      end
      results_owed <= expected_beats.size();
   end

endmodule

// ----- verif/tb_vector_l2_normaliser_unit.sv -----
// Testbench top for the L2 vector normaliser: stimulus, receiver stalls and verdict.
module tb_vector_l2_normaliser_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import vnl_pkg::*;

   localparam int LONG_HOLD_CYCLES = 500;
   localparam int PHASE_ITEMS      = 68;
   localparam int SETTLE_CYCLES    = 60;

   logic    clock         = 1'b0;
   logic    reset         = 1'b1;
   logic    req_valid     = 1'b0;
   req_type req_data      = '0;
   logic    rsp_stall     = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int      mismatch_count;
   int      results_owed;
   int      send_idle_pct = 0;
   int      stall_pct     = 0;
   logic    long_hold_req = 1'b0;
   int      hold_left     = 0;
   int      items_sent    = 0;

   vector_l2_normaliser_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   vnl_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, or one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (long_hold_req) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD_CYCLES;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offer one element beat, with random idle cycles first
   task automatic send_element(input logic signed [ELEM_W-1:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {value, last};
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Stop offering and wait until every predicted result beat has arrived
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   // One vector of random length and content
   task automatic send_random_vector();
      int                       pick;
      int                       len;
      int                       flavour;
      logic signed [ELEM_W-1:0] value;
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(1, 6);
      else if (pick < 90) len = $urandom_range(7, 16);
      else len = $urandom_range(17, 20);
      flavour = $urandom_range(9);
      for (int i = 0; i < len; i++) begin
         case (flavour)
            0: value = '0;
            1: value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            2, 3: value = ELEM_W'($urandom_range(31)) - 16'sd16;
            default: value = ELEM_W'($urandom());
         endcase
         send_element(value, i == len - 1);
      end
   endtask

   // Stimulus and verdict
   initial begin
      int phase_start;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: full-scale single element
      send_element(16'sh7FFF, 1'b1);
      // Largest sum, store overflow, final on a discarded element
      for (int i = 0; i < 17; i++) send_element(16'sh8000, i == 16);
      // All-zero vector gives zero root, then the vector (3, 4)
      send_element(16'sd0, 1'b0);
      send_element(16'sd0, 1'b1);
      send_element(16'sd3, 1'b0);
      send_element(16'sd4, 1'b1);
      // Root rounds down to the element magnitude
      send_element(16'sd1, 1'b0);
      send_element(-16'sd1, 1'b0);
      send_element(16'sd1, 1'b1);
      wait_results_drained();

      // Random phases with different idling, drained between phases
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 63; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 63; end
            default: begin send_idle_pct = 14; stall_pct <= 14; end
         endcase
         if (ph == 0) begin
            // long receiver hold-off while the sender keeps offering
            long_hold_req <= 1'b1;
            @(posedge clock);
            long_hold_req <= 1'b0;
         end
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) send_random_vector();
         wait_results_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("vector_l2_normaliser_unit regression: pass");
      end else begin
         $display("vector_l2_normaliser_unit regression: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("vector_l2_normaliser_unit regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/vnl_pkg.sv
design/vnl_sqrt.sv
design/vnl_div.sv
design/vector_l2_normaliser_unit.sv
verif/vnl_result_checker.sv
verif/tb_vector_l2_normaliser_unit.sv
